### rtl/brlt_pkg.sv
// package: types, widths and codes of the byte-range lock table
package brlt_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MAX_WAKES   = 16;
  localparam int WAKE_W      = $clog2(MAX_WAKES + 1);

  localparam logic [63:0] HIGH_OFFSET = 64'h0000_0000_EF00_0000;
  localparam int TOP_BIT = 63;

  localparam int IN_DATA_W  = 216;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1;

  typedef enum logic [1:0] {
    CMD_LOCK   = 2'd0,
    CMD_UNLOCK = 2'd1,
    CMD_TEST   = 2'd2,
    CMD_CLOSE  = 2'd3
  } cmd_t;

  localparam logic [1:0] K_READ  = 2'd0;
  localparam logic [1:0] K_WRITE = 2'd1;
  localparam logic [1:0] K_PEND  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CONFLICT  = 3'd1;
  localparam logic [2:0] ST_NOT_GRANT = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_TEST_HIT  = 3'd5;

  localparam logic KIND_FINAL = 1'b0;
  localparam logic KIND_WAKE  = 1'b1;

  typedef struct packed {
    logic        flav;
    logic [1:0]  kind;
    logic [15:0] handle;
    logic [63:0] owner;
    logic [63:0] size;
    logic [63:0] start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/byte_range_lock_table.sv
// top level: byte-range lock table for one file, scanned through one ram
//
// usage:
//   in_*  channel carries one request: lock, unlock, test or close-handle
//         (command in in_tuser); in_tready is high only while the block is idle
//   out_* channel returns zero or more wake notices (out_tuser = 1) and then
//         exactly one final status (out_tuser = 0, out_tlast = 1)
// sequence:
//   each entry visit is a ram read state (S_RD) and an evaluate state (S_EV);
//   lock and test scan the entries in order, stop at the first hit and then
//   load their status; the block is idle again once that status is loaded.
//   unlock of a non-pending entry and close add a waiter scan over all entries,
//   and every removal adds a compaction of the entries above it; close repeats
//   that per removed entry, and every stalled wake notice adds its wait
// reset:
//   entry count and the last-failure record clear at once; the ram contents
//   are not cleared, entries at or above the count are never read
// stall:
//   results sit in an output register; while it is full and out_tready is
//   low the sequencer waits in its wake or final state, the table is left untouched
module byte_range_lock_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // client_pid, server_pid, tree_id, file_handle, range_start, range_size,
  // lock_kind, flavour, pending_only, zero fill
  input  logic [brlt_pkg::IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic [brlt_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status, own_context, pre_unlock, wake_pid, zero fill
  output logic [brlt_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic [brlt_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                           out_tlast
);

  import brlt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EV, S_WRD, S_WEV, S_SHRD, S_SHWR, S_FINAL
  } state_t;

  state_t state_r;

  // request registers
  cmd_t        cmd_r;
  logic [63:0] r_owner_r;
  logic [15:0] r_handle_r;
  logic [63:0] r_start_r;
  logic [63:0] r_size_r;
  logic [63:0] r_end_r;
  logic [1:0]  r_kind_r;
  logic        r_flav_r;
  logic        pend_only_r;

  // scan state
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  j_r;
  logic [WAKE_W-1:0] wakes_r;
  logic [63:0]       e_start_r;
  logic [63:0]       e_end_r;

  // last failure record
  logic [63:0] fail_owner_r;
  logic [15:0] fail_handle_r;
  logic [63:0] fail_start_r;
  logic [63:0] fail_size_r;

  // final status fields
  logic [2:0] fin_status_r;
  logic       fin_own_r;
  logic       fin_pre_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_kind_r;
  logic                  out_last_r;

  // ram port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             ent;
  entry_t             req_ent;

  logic [CNT_W-1:0] jp1;
  logic             out_free;
  logic             table_full;

  // evaluation of the entry just read
  logic [63:0] ent_end;
  logic        ovl;
  logic        same_owner;
  logic        same_handle;
  logic        lock_hit;
  logic        test_hit;
  logic        exact_hit;
  logic        key_hit;
  logic        fail_repeat;
  logic        wake_ovl;
  logic        wake_want;
  logic [63:0] p_end;

  assign ent        = entry_t'(ram_rdata);
  assign jp1        = j_r + 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign table_full = (cnt_r >= CNT_W'(TABLE_DEPTH));
  assign in_tready  = (state_r == S_IDLE);

  assign req_ent.flav   = r_flav_r;
  assign req_ent.kind   = r_kind_r;
  assign req_ent.handle = r_handle_r;
  assign req_ent.owner  = r_owner_r;
  assign req_ent.size   = r_size_r;
  assign req_ent.start  = r_start_r;

  always_comb begin
    ent_end     = ent.start + ent.size;
    same_owner  = (ent.owner == r_owner_r);
    same_handle = (ent.handle == r_handle_r);
    ovl = (ent.size != 64'd0 && ent.start == r_start_r && ent.size == r_size_r) ||
          !(ent.start >= r_end_r || r_start_r >= ent_end);
    // lock rule: pending and read/read exemptions, same-owner same-handle read exemption
    lock_hit = !(ent.kind == K_PEND || r_kind_r == K_PEND) &&
               !(ent.kind == K_READ && r_kind_r == K_READ) &&
               !(same_owner && r_kind_r == K_READ && same_handle) && ovl;
    // test rule: read/write-path exemptions
    test_hit = !(ent.kind == K_PEND || r_kind_r == K_PEND) &&
               !(ent.kind == K_READ && r_kind_r == K_READ) &&
               !(ent.flav && r_flav_r) &&
               !(!(r_kind_r == K_WRITE && ent.kind == K_READ) &&
                 same_owner && same_handle) && ovl;
    exact_hit = same_owner && same_handle && ent.start == r_start_r &&
                ent.size == r_size_r && (!pend_only_r || ent.kind == K_PEND);
    key_hit   = (ent.owner[63:16] == r_owner_r[63:16]) && same_handle;
    fail_repeat = (fail_owner_r == r_owner_r) && (fail_handle_r == r_handle_r) &&
                  (fail_start_r == r_start_r) && (fail_size_r == r_size_r);
    // waiter overlap against the entry being removed
    p_end    = ent.start + ent.size;
    wake_ovl = (e_start_r <= ent.start && e_end_r > ent.start) ||
               (e_start_r >= ent.start && e_start_r <= p_end);
    wake_want = (ent.kind == K_PEND) && wake_ovl &&
                !(cmd_r == CMD_CLOSE && key_hit);
  end

  // ram control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[IDX_W-1:0];
    ram_wdata = req_ent;
    ram_re    = 1'b0;
    ram_raddr = i_r[IDX_W-1:0];
    unique case (state_r)
      S_RD: begin
        if (i_r < cnt_r) begin
          ram_re = 1'b1;
        end else if (cmd_r == CMD_LOCK && !table_full) begin
          ram_we = 1'b1;
        end
      end
      S_WRD: begin
        ram_re    = (j_r < cnt_r);
        ram_raddr = j_r[IDX_W-1:0];
      end
      S_SHRD: begin
        ram_re    = (jp1 < cnt_r);
        ram_raddr = jp1[IDX_W-1:0];
      end
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[IDX_W-1:0];
        ram_wdata = ent;
      end
      default: begin
      end
    endcase
  end

  brlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      fail_owner_r  <= '0;
      fail_handle_r <= '0;
      fail_start_r  <= '0;
      fail_size_r   <= '0;
      out_valid_r   <= 1'b0;
      wakes_r       <= '0;
      i_r           <= '0;
      j_r           <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r        <= cmd_t'(in_tuser);
            r_owner_r    <= {in_tdata[47:16], in_tdata[63:48], in_tdata[15:0]};
            r_handle_r   <= in_tdata[79:64];
            r_start_r    <= in_tdata[143:80];
            r_size_r     <= in_tdata[207:144];
            r_end_r      <= in_tdata[143:80] + in_tdata[207:144];
            // kind three is kept as a write lock
            r_kind_r     <= (in_tdata[209:208] == 2'd3) ? K_WRITE : in_tdata[209:208];
            r_flav_r     <= in_tdata[210];
            pend_only_r  <= in_tdata[211];
            i_r          <= '0;
            wakes_r      <= '0;
            fin_own_r    <= 1'b0;
            fin_pre_r    <= 1'b0;
            fin_status_r <= ST_OK;
            if (in_tdata[210] && cmd_t'(in_tuser) == CMD_LOCK) begin
              fin_status_r <= ST_NOT_GRANT;
              state_r      <= S_FINAL;
            end else if (in_tdata[210] && cmd_t'(in_tuser) == CMD_UNLOCK) begin
              state_r <= S_FINAL;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          if (i_r < cnt_r) begin
            state_r <= S_EV;
          end else begin
            // end of scan without a hit
            case (cmd_r)
              CMD_LOCK: begin
                if (table_full) begin
                  fin_status_r <= ST_FULL;
                end else begin
                  cnt_r <= cnt_r + 1'b1;
                end
              end
              CMD_UNLOCK: fin_status_r <= ST_NOT_FOUND;
              default:    fin_status_r <= ST_OK;
            endcase
            state_r <= S_FINAL;
          end
        end
        S_EV: begin
          state_r <= S_RD;
          i_r     <= i_r + 1'b1;
          unique case (cmd_r)
            CMD_LOCK: begin
              if (lock_hit) begin
                i_r       <= i_r;
                fin_own_r <= same_owner;
                if (fail_repeat) begin
                  fin_status_r <= ST_CONFLICT;
                end else begin
                  fail_owner_r  <= r_owner_r;
                  fail_handle_r <= r_handle_r;
                  fail_start_r  <= r_start_r;
                  fail_size_r   <= r_size_r;
                  fin_status_r  <= (r_start_r >= HIGH_OFFSET && !r_start_r[TOP_BIT]) ?
                                   ST_CONFLICT : ST_NOT_GRANT;
                end
                state_r <= S_FINAL;
              end
            end
            CMD_TEST: begin
              if (test_hit) begin
                fin_status_r <= ST_TEST_HIT;
                state_r      <= S_FINAL;
              end
            end
            CMD_UNLOCK: begin
              if (exact_hit) begin
                i_r       <= i_r;
                e_start_r <= ent.start;
                e_end_r   <= ent_end;
                if (ent.kind != K_PEND) begin
                  fin_pre_r <= 1'b1;
                  j_r       <= '0;
                  state_r   <= S_WRD;
                end else begin
                  j_r     <= i_r;
                  state_r <= S_SHRD;
                end
              end
            end
            CMD_CLOSE: begin
              if (key_hit) begin
                i_r       <= i_r;
                e_start_r <= ent.start;
                e_end_r   <= ent_end;
                j_r       <= '0;
                state_r   <= S_WRD;
              end
            end
            default: begin
            end
          endcase
        end
        S_WRD: begin
          if (j_r < cnt_r) begin
            state_r <= S_WEV;
          end else begin
            j_r     <= i_r;
            state_r <= S_SHRD;
          end
        end
        S_WEV: begin
          if (wake_want && wakes_r < WAKE_W'(MAX_WAKES)) begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= KIND_WAKE;
              out_last_r  <= 1'b0;
              out_data_r  <= {3'b000, ent.owner[63:32], 5'b00000};
              wakes_r     <= wakes_r + 1'b1;
              j_r         <= jp1;
              state_r     <= S_WRD;
            end
          end else begin
            j_r     <= jp1;
            state_r <= S_WRD;
          end
        end
        S_SHRD: begin
          if (jp1 < cnt_r) begin
            state_r <= S_SHWR;
          end else begin
            // compaction done
            cnt_r <= cnt_r - 1'b1;
            if (cmd_r == CMD_CLOSE) begin
              state_r <= S_RD;
            end else begin
              fin_status_r <= ST_OK;
              state_r      <= S_FINAL;
            end
          end
        end
        S_SHWR: begin
          j_r     <= jp1;
          state_r <= S_SHRD;
        end
        S_FINAL: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_FINAL;
            out_last_r  <= 1'b1;
            out_data_r  <= {3'b000, 32'd0, fin_pre_r, fin_own_r, fin_status_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // entry count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // wake notices per command stay within the cap
  a_wake_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wakes_r <= WAKE_W'(MAX_WAKES))
    else $error("too many wake notices");

  // the table is never written while a request may be accepted
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !ram_we)
    else $error("ram write while idle");

  // a final status always brings the block back to idle
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINAL && out_free) |=> (state_r == S_IDLE && out_tvalid && out_tlast))
    else $error("final status not issued");

endmodule

### rtl/brlt_ram.sv
// generic single-write, single-read ram with registered read data
module brlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### bench/lock_table_checker.sv
// checker: predicts lock table results and compares them with the result stream
module lock_table_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [brlt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [brlt_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [brlt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [brlt_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                            out_tlast,
  output int                              fail_count,
  output int                              pending_results,
  output int                              result_total,
  output int                              wake_total
);
  timeunit 1ns;
  timeprecision 1ps;
  import brlt_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic        own;
    logic        pre;
    logic [31:0] wake_pid;
    logic        last;
  } lock_result_t;

  entry_t       tbl [TABLE_DEPTH];
  int           tbl_count;
  logic [63:0]  fail_owner, fail_start, fail_size;
  logic [15:0]  fail_handle;
  lock_result_t expected_results [$];

  function automatic logic ranges_hit(entry_t a, entry_t b);
    if (a.size != 0 && a.start == b.start && a.size == b.size) return 1'b1;
    if (a.start >= b.start + b.size || b.start >= a.start + a.size) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic waiter_hit(entry_t l, entry_t p);
    if (l.start <= p.start && l.start + l.size > p.start) return 1'b1;
    if (l.start >= p.start && l.start <= p.start + p.size) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic lock_blocks(entry_t e, entry_t r);
    if (e.kind == K_PEND || r.kind == K_PEND) return 1'b0;
    if (e.kind == K_READ && r.kind == K_READ) return 1'b0;
    if (e.owner == r.owner && r.kind == K_READ && e.handle == r.handle) return 1'b0;
    return ranges_hit(e, r);
  endfunction

  function automatic logic test_blocks(entry_t e, entry_t r);
    if (e.kind == K_PEND || r.kind == K_PEND) return 1'b0;
    if (e.kind == K_READ && r.kind == K_READ) return 1'b0;
    if (e.flav && r.flav) return 1'b0;
    if (!(r.kind == K_WRITE && e.kind == K_READ))
      if (e.owner == r.owner && e.handle == r.handle) return 1'b0;
    return ranges_hit(e, r);
  endfunction

  task automatic drop_at(int i);
    for (int k = i; k + 1 < tbl_count; k++) tbl[k] = tbl[k + 1];
    tbl_count--;
  endtask

  task automatic push_final(logic [2:0] st, logic own, logic pre);
    lock_result_t x;
    x = '{kind: KIND_FINAL, status: st, own: own, pre: pre, wake_pid: '0, last: 1'b1};
    expected_results.push_back(x);
  endtask

  task automatic push_wake(ref int n, input logic [63:0] owner);
    lock_result_t x;
    if (n >= MAX_WAKES) return;
    x = '{kind: KIND_WAKE, status: ST_OK, own: 1'b0, pre: 1'b0,
          wake_pid: owner[63:32], last: 1'b0};
    expected_results.push_back(x);
    n++;
  endtask

  task automatic predict_request(logic [IN_DATA_W-1:0] d, logic [1:0] cmd);
    entry_t r, e;
    logic pend_only, found;
    logic [63:0] key;
    logic [2:0] st;
    int n, i;
    n = 0;
    r.owner = {d[47:16], d[63:48], d[15:0]};
    r.handle = d[79:64];
    r.start = d[143:80];
    r.size = d[207:144];
    r.kind = (d[209:208] == 2'd3) ? K_WRITE : d[209:208];
    r.flav = d[210];
    pend_only = d[211];
    case (cmd)
      CMD_LOCK: begin
        if (r.flav) begin
          push_final(ST_NOT_GRANT, 0, 0);
          return;
        end
        for (i = 0; i < tbl_count; i++) begin
          if (lock_blocks(tbl[i], r)) begin
            if (fail_owner == r.owner && fail_handle == r.handle &&
                fail_start == r.start && fail_size == r.size) begin
              st = ST_CONFLICT;
            end else begin
              fail_owner = r.owner; fail_handle = r.handle;
              fail_start = r.start; fail_size = r.size;
              st = (r.start >= HIGH_OFFSET && !r.start[TOP_BIT]) ? ST_CONFLICT
                                                                 : ST_NOT_GRANT;
            end
            push_final(st, tbl[i].owner == r.owner, 0);
            return;
          end
        end
        if (tbl_count >= TABLE_DEPTH) begin
          push_final(ST_FULL, 0, 0);
          return;
        end
        tbl[tbl_count] = r;
        tbl_count++;
        push_final(ST_OK, 0, 0);
      end
      CMD_UNLOCK: begin
        if (r.flav) begin
          push_final(ST_OK, 0, 0);
          return;
        end
        for (i = 0; i < tbl_count; i++) begin
          e = tbl[i];
          if (!(e.owner == r.owner && e.handle == r.handle &&
                e.start == r.start && e.size == r.size)) continue;
          if (pend_only && e.kind != K_PEND) continue;
          if (e.kind != K_PEND)
            for (int j = 0; j < tbl_count; j++)
              if (tbl[j].kind == K_PEND && waiter_hit(e, tbl[j]))
                push_wake(n, tbl[j].owner);
          drop_at(i);
          push_final(ST_OK, 0, e.kind != K_PEND);
          return;
        end
        push_final(ST_NOT_FOUND, 0, 0);
      end
      CMD_TEST: begin
        found = 1'b0;
        for (i = 0; i < tbl_count; i++) if (test_blocks(tbl[i], r)) found = 1'b1;
        push_final(found ? ST_TEST_HIT : ST_OK, 0, 0);
      end
      default: begin
        // close-handle: drop every entry of this tid, pid and handle
        key = {r.owner[63:16], 16'h0};
        i = 0;
        while (i < tbl_count) begin
          e = tbl[i];
          if ({e.owner[63:16], 16'h0} == key && e.handle == r.handle) begin
            for (int j = 0; j < tbl_count; j++) begin
              if (tbl[j].kind != K_PEND) continue;
              if ({tbl[j].owner[63:16], 16'h0} == key && tbl[j].handle == r.handle)
                continue;
              if (waiter_hit(e, tbl[j])) push_wake(n, tbl[j].owner);
            end
            drop_at(i);
          end else begin
            i++;
          end
        end
        push_final(ST_OK, 0, 0);
      end
    endcase
  endtask

  lock_result_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      tbl_count <= 0;
      fail_owner = '0; fail_start = '0; fail_size = '0; fail_handle = '0;
      fail_count <= 0;
      result_total <= 0;
      wake_total <= 0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{kind: out_tuser[0], status: out_tdata[2:0], own: out_tdata[3],
                pre: out_tdata[4], wake_pid: out_tdata[36:5], last: out_tlast};
        result_total <= result_total + 1;
        if (got.kind) wake_total <= wake_total + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("mismatch: kind %0d/%0d status %0d/%0d own %0d/%0d (exp/got)",
                       want.kind, got.kind, want.status, got.status, want.own, got.own);
              $display("          pre %0d/%0d pid %h/%h last %0d/%0d",
                       want.pre, got.pre, want.wake_pid, got.wake_pid,
                       want.last, got.last);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) predict_request(in_tdata, in_tuser);
    end
    pending_results = expected_results.size();
  end
endmodule

### bench/testbench.sv
// testbench top: drives lock table requests, stalls the result side, gives the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brlt_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  int fail_count, pending_results, result_total, wake_total;
  int cycle_count = 0;
  int request_total = 0;
  logic calm = 1'b0;   // no idling in the last part of the run

  localparam int CYCLE_LIMIT = 400000;

  always #5 clk = ~clk;

  byte_range_lock_table u_dut (.*);

  lock_table_checker u_chk (.*);

  // small pools of owners, handles and offsets so entries collide often
  logic [15:0] cpid_pool [4] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h1234};
  logic [31:0] pid_pool  [3] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0042};
  logic [15:0] tid_pool  [2] = '{16'h0000, 16'hFFFF};
  logic [15:0] fh_pool   [3] = '{16'h0000, 16'hFFFF, 16'h0007};
  logic [63:0] off_pool  [6] = '{64'h0, 64'h10, 64'h20, 64'hEF00_0000,
                                 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000_0000_0000_0000};
  logic [63:0] sz_pool   [5] = '{64'h0, 64'h1, 64'h10, 64'h40, 64'hFFFF_FFFF_FFFF_FFFF};

  // result side: random stall bursts until the calm part
  int stall_left = 0;
  always @(posedge clk) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left <= $urandom_range(1, 3);
    else if (stall_left > 0)
      stall_left <= stall_left - 1;
    out_tready <= calm || (stall_left == 0);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // one request held until its handshake, then an optional gap
  task automatic send_request(logic [1:0] cmd, logic [15:0] cpid, logic [31:0] pid,
                              logic [15:0] tid, logic [15:0] fh, logic [63:0] st,
                              logic [63:0] sz, logic [1:0] lk, logic fl, logic po);
    in_tdata  <= {4'b0, po, fl, lk, sz, st, fh, tid, pid, cpid};
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    request_total++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_random(logic [1:0] cmd);
    logic [63:0] st, sz;
    st = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : off_pool[$urandom_range(0, 5)];
    sz = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : sz_pool[$urandom_range(0, 4)];
    send_request(cmd,
                 ($urandom_range(0, 9) == 0) ? 16'($urandom) : cpid_pool[$urandom_range(0, 3)],
                 ($urandom_range(0, 9) == 0) ? $urandom : pid_pool[$urandom_range(0, 2)],
                 tid_pool[$urandom_range(0, 1)],
                 ($urandom_range(0, 9) == 0) ? 16'($urandom) : fh_pool[$urandom_range(0, 2)],
                 st, sz, 2'($urandom_range(0, 3)), $urandom_range(0, 7) == 0,
                 $urandom_range(0, 3) == 0);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    logic [1:0] cmd;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a lock at offset zero, then zero-size locks there that overlap nothing and are granted
    send_request(CMD_LOCK, 0, 0, 0, 0, 0, 64'h10, K_WRITE, 0, 0);
    send_request(CMD_LOCK, 0, 0, 0, 0, 0, 0, K_WRITE, 0, 0);
    send_request(CMD_LOCK, 16'h1, 0, 0, 0, 0, 0, K_WRITE, 0, 0);
    // high offset conflict and top-bit offset
    send_request(CMD_LOCK, 16'h1, 1, 0, 0, 64'hEF00_0000, 64'h10, K_WRITE, 0, 0);
    send_request(CMD_LOCK, 16'h2, 1, 0, 0, 64'hEF00_0004, 64'h4, K_READ, 0, 0);
    send_request(CMD_LOCK, 16'h1, 1, 0, 0, 64'h8000_0000_0000_0000, '1, K_WRITE, 0, 0);
    send_request(CMD_LOCK, 16'h2, 1, 0, 0, 64'h8000_0000_0000_0000, 1, K_WRITE, 0, 0);
    // pending waiters, lock kind three, posix lock and unlock
    send_request(CMD_LOCK, 16'h5, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 64'h4, 64'h8, K_PEND, 0, 0);
    send_request(CMD_LOCK, 16'h6, 32'h42, 0, 7, 64'h100, 64'h10, 2'd3, 0, 0);
    send_request(CMD_LOCK, 16'h6, 32'h42, 0, 7, 64'h100, 64'h10, K_READ, 1, 0);
    send_request(CMD_UNLOCK, 16'h6, 32'h42, 0, 7, 64'h100, 64'h10, K_READ, 1, 1);
    send_request(CMD_TEST, 16'h7, 32'h43, 0, 7, 64'h108, 64'h1, K_WRITE, 1, 0);
    send_request(CMD_TEST, 16'h7, 32'h43, 0, 7, 64'h108, 64'h1, K_READ, 0, 0);
    // unlock with waiter wake, pending-only miss, not found
    send_request(CMD_UNLOCK, 0, 0, 0, 0, 0, 64'h10, K_READ, 0, 1);
    send_request(CMD_UNLOCK, 0, 0, 0, 0, 0, 64'h10, K_READ, 0, 0);
    send_request(CMD_UNLOCK, 0, 0, 0, 0, 0, 64'h10, K_READ, 0, 0);
    // fill the table to full
    for (int i = 0; i < 8; i++)
      send_request(CMD_LOCK, 16'(i), 32'h9, 0, 3, 64'h1000 + 64'(i) * 64'h10, 64'h10,
                   K_READ, 0, 0);
    send_request(CMD_CLOSE, 16'hFFFF, 32'h9, 0, 3, 0, 0, K_READ, 0, 0);
    drain();  // hold off until every expected result is in

    for (int n = 0; n < 220; n++) begin
      if (n == 110) drain();
      if (n == 180) calm = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cmd = CMD_LOCK;
        4, 5, 6:    cmd = CMD_UNLOCK;
        7, 8:       cmd = CMD_TEST;
        default:    cmd = CMD_CLOSE;
      endcase
      send_random(cmd);
    end
    drain();
    repeat (100) @(posedge clk);

    $display("sent %0d requests, checked %0d results including %0d wake notices",
             request_total, result_total, wake_total);
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
